### rtl/fbape_pkg.sv
// fbape_pkg: shared constants, types and the divide-by-255 helper
// for the alpha pixel engine; no dependencies
package fbape_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // fixed field widths
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int DIM_W      = 10;
  localparam int GA_W       = 9;
  localparam int GA_MAX     = 256;

  // widths derived from the framebuffer size
  localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WS_W   = $clog2(MAX_WIDTH + 1);
  localparam int HS_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = ((WS_W > HS_W) ? WS_W : HS_W) > COORD_W ?
                          ((WS_W > HS_W) ? WS_W : HS_W) : COORD_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ALPHA  = 2'd2;

  typedef enum logic [1:0] {
    MODE_WRITE,
    MODE_PIXEL_BLEND,
    MODE_GLOBAL_BLEND,
    MODE_READ
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic mix;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic  clip;
    mode_t mode;
    logic  color_zero;
  } sts_t;

  // floor(m / 255) for m <= 65025: reciprocal estimate, then one correction
  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [24:0] prod;
    logic [7:0]  q0;
    logic [15:0] back;
    logic [15:0] rem;
    prod = {9'd0, m} + {1'b0, m, 8'd0};
    q0   = prod[23:16];
    back = {q0, 8'd0} - {8'd0, q0};
    rem  = m - back;
    if (rem >= 16'd255) begin
      q0 = q0 + 8'd1;
    end
    return q0;
  endfunction

endpackage

### rtl/fbape_if.sv
// fbape_if: valid/ready channel interfaces for pixel operations and results
// depends on fbape_pkg
interface fbape_in_if import fbape_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [COLOR_W-1:0]        src_color;

  modport source (output valid, mode, pos_x, pos_y, src_color, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, src_color, output ready);
endinterface

interface fbape_out_if import fbape_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;
  logic               wrote;
  logic               clipped;

  modport source (output valid, read_color, wrote, clipped, input ready);
  modport sink   (input valid, read_color, wrote, clipped, output ready);
endinterface

### rtl/fbape_ctrl.sv
// fbape_ctrl: sequencer for one pixel operation at a time
// depends on fbape_pkg
module fbape_ctrl import fbape_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.calc = 1'b1;
        if (sts.clip || sts.mode == MODE_WRITE ||
            (sts.mode == MODE_PIXEL_BLEND && sts.color_zero)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = (sts.mode == MODE_READ) ? ST_DONE : ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result loaded while output register still occupied");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished operation did not present a result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ADDR))
    else $error("accepted transaction did not start address stage");

  a_clip_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR && sts.clip) |=> (state_r == ST_DONE))
    else $error("clipped transaction touched the framebuffer");

endmodule

### rtl/fbape_dp.sv
// fbape_dp: configuration registers, clip and address logic, framebuffer
// memory, per-channel blend and result register; depends on fbape_pkg
module fbape_dp import fbape_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [1:0]                in_mode,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic [COLOR_W-1:0]        in_src_color,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  output logic [COLOR_W-1:0]        res_read_color,
  output logic                      res_wrote,
  output logic                      res_clipped
);

  logic [DIM_W-1:0] width_r, height_r;
  logic [GA_W-1:0]  ga_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
      ga_r     <= GA_W'(GA_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_GLOBAL_ALPHA:  ga_r     <= cfg_wdata[GA_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated screen size and global alpha
  logic [WS_W-1:0] w_sat;
  logic [HS_W-1:0] h_sat;
  logic [GA_W-1:0] ga_sat;
  assign w_sat  = (width_r > DIM_W'(MAX_WIDTH)) ? WS_W'(MAX_WIDTH) : WS_W'(width_r);
  assign h_sat  = (height_r > DIM_W'(MAX_HEIGHT)) ? HS_W'(MAX_HEIGHT) : HS_W'(height_r);
  assign ga_sat = (ga_r > GA_W'(GA_MAX)) ? GA_W'(GA_MAX) : ga_r;

  // clip test on the incoming coordinates
  logic [CMP_W-1:0] x_mag, y_mag;
  logic             clip_in;
  assign x_mag   = CMP_W'(in_pos_x[COORD_W-2:0]);
  assign y_mag   = CMP_W'(in_pos_y[COORD_W-2:0]);
  assign clip_in = in_pos_x[COORD_W-1] || in_pos_y[COORD_W-1] ||
                   (x_mag >= CMP_W'(w_sat)) || (y_mag >= CMP_W'(h_sat));

  mode_t              mode_r;
  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [COLOR_W-1:0] color_r;
  logic               clip_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= mode_t'(in_mode);
      x_r     <= in_pos_x[X_W-1:0];
      y_r     <= in_pos_y[Y_W-1:0];
      color_r <= in_src_color;
      clip_r  <= clip_in;
    end
  end

  assign sts.clip       = clip_r;
  assign sts.mode       = mode_r;
  assign sts.color_zero = (color_r == '0);

  // word address and blend weight
  logic [Y_W+WS_W-1:0] yw_prod;
  logic [Y_W+WS_W:0]   addr_full;
  logic [ADDR_W-1:0]   addr_r;
  logic [GA_W+7:0]     ga_prod;
  logic [15:0]         num_r;
  assign yw_prod   = y_r * w_sat;
  assign addr_full = {1'b0, yw_prod} + (Y_W+WS_W+1)'(x_r);
  assign ga_prod   = color_r[31:24] * ga_sat;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      addr_r <= addr_full[ADDR_W-1:0];
      num_r  <= (mode_r == MODE_GLOBAL_BLEND) ? ga_prod[15:0] : {8'd0, color_r[31:24]};
    end
  end

  // framebuffer memory, read data registered
  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;
  logic [COLOR_W-1:0] wdata;
  logic               wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr_r];
  end

  // per-channel difference magnitude times weight
  logic [2:0][23:0] mag_r;
  logic [2:0]       neg_r;
  logic [2:0][23:0] mag_prod;
  logic [2:0][7:0]  dmag;
  logic [2:0]       dneg;
  logic [2:0][8:0]  diff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]     = {1'b0, color_r[8*c +: 8]} - {1'b0, rdata_r[8*c +: 8]};
      dneg[c]     = diff[c][8];
      dmag[c]     = dneg[c] ? 8'(-diff[c]) : diff[c][7:0];
      mag_prod[c] = dmag[c] * num_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      mag_r <= mag_prod;
      neg_r <= dneg;
    end
  end

  // divide by 255 (and by 256 more for the global blend), apply sign
  logic [2:0][15:0] dividend;
  logic [2:0][7:0]  quot;
  logic [23:0]      blend_rgb;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dividend[c] = (mode_r == MODE_GLOBAL_BLEND) ? mag_r[c][23:8] : mag_r[c][15:0];
      quot[c]     = div255(dividend[c]);
      blend_rgb[8*c +: 8] = neg_r[c] ? (rdata_r[8*c +: 8] - quot[c])
                                     : (rdata_r[8*c +: 8] + quot[c]);
    end
  end

  logic do_write;
  always_comb begin
    do_write = 1'b0;
    wdata    = color_r;
    case (mode_r)
      MODE_WRITE: begin
        do_write = 1'b1;
        wdata    = color_r;
      end
      MODE_PIXEL_BLEND: begin
        do_write = !sts.color_zero;
        wdata    = {8'hFF, blend_rgb};
      end
      MODE_GLOBAL_BLEND: begin
        do_write = 1'b1;
        wdata    = {rdata_r[31:24], blend_rgb};
      end
      MODE_READ: begin
        do_write = 1'b0;
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  assign wr_en = cmd.finish && do_write && !clip_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_read_color <= (mode_r == MODE_READ && !clip_r) ? rdata_r : '0;
      res_wrote      <= do_write && !clip_r;
      res_clipped    <= clip_r;
    end
  end

endmodule

### rtl/framebuffer_alpha_pixel_engine_core.sv
// framebuffer_alpha_pixel_engine_core: top level of the ARGB8888 pixel engine
// depends on fbape_pkg, fbape_if, fbape_ctrl and fbape_dp
//
// usage
// - in_ch carries one pixel operation per transaction: mode, signed pos_x and
//   pos_y, and src_color (ARGB8888, alpha in the top byte)
// - mode: opaque write, per-pixel alpha blend (skipped on a zero color, stores
//   alpha 255), global-times-pixel alpha blend (keeps stored alpha), or read
// - out_ch returns exactly one result per operation: read_color, wrote, clipped
// - cfg_we/cfg_index/cfg_wdata write screen width, screen height and global
//   alpha (Q8); write them only while the engine is idle
// - one operation is in flight at a time; the sequencer steps from idle to
//   address, read, mix and done, where a clipped operation, an opaque write
//   or a skipped blend skips read and mix and a read skips mix; it is idle
//   again as the result loads, so the next operation can be accepted only then
// - the blend path is a read-modify-write of one word in the synchronous
//   framebuffer memory
// - a finished result sits in an output register, so the engine accepts the
//   next operation while out_ch is stalled; it holds the following result
//   until the register empties
// - reset (rst_n low, synchronous) returns the sequencer to idle, drops
//   out_ch.valid and restores 512 x 512 screen and opaque global alpha;
//   framebuffer contents are undefined until written
module framebuffer_alpha_pixel_engine_core import fbape_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fbape_in_if.sink              in_ch,
  fbape_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  fbape_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds config, framebuffer and the result register
  fbape_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_ch.mode),
    .in_pos_x       (in_ch.pos_x),
    .in_pos_y       (in_ch.pos_y),
    .in_src_color   (in_ch.src_color),
    .cmd            (cmd),
    .sts            (sts),
    .res_read_color (out_ch.read_color),
    .res_wrote      (out_ch.wrote),
    .res_clipped    (out_ch.clipped)
  );

endmodule
